// ----- rtl/smes_pkg.sv -----
// Package for the stack machine execute step block.
// Holds the item structs, opcode and tag codes, and parameter defaults.
// No dependencies.
package smes_pkg;

  localparam int unsigned MEM_WORDS_DEF = 4096;
  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned PROG_LINES_W  = 13;

  localparam logic KIND_EXEC    = 1'b0;
  localparam logic KIND_PRELOAD = 1'b1;

  localparam logic [1:0] TAG_INSTR = 2'd0;
  localparam logic [1:0] TAG_SKIP  = 2'd1;

  localparam logic [7:0] OP_LDC  = 8'd0;
  localparam logic [7:0] OP_ADC  = 8'd1;
  localparam logic [7:0] OP_LDL  = 8'd2;
  localparam logic [7:0] OP_STL  = 8'd3;
  localparam logic [7:0] OP_LDNL = 8'd4;
  localparam logic [7:0] OP_STNL = 8'd5;
  localparam logic [7:0] OP_ADD  = 8'd6;
  localparam logic [7:0] OP_SUB  = 8'd7;
  localparam logic [7:0] OP_SHL  = 8'd8;
  localparam logic [7:0] OP_SHR  = 8'd9;
  localparam logic [7:0] OP_ADJ  = 8'd10;
  localparam logic [7:0] OP_A2SP = 8'd11;
  localparam logic [7:0] OP_SP2A = 8'd12;
  localparam logic [7:0] OP_CALL = 8'd13;
  localparam logic [7:0] OP_RET  = 8'd14;
  localparam logic [7:0] OP_BRZ  = 8'd15;
  localparam logic [7:0] OP_BRLZ = 8'd16;
  localparam logic [7:0] OP_BR   = 8'd17;
  localparam logic [7:0] OP_HALT = 8'd18;

  typedef struct packed {
    logic               item_kind;
    logic [1:0]         line_tag;
    logic [7:0]         opcode;
    logic signed [23:0] operand;
    logic [11:0]        load_address;
    logic signed [31:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] reg_a;
    logic signed [31:0] reg_b;
    logic signed [31:0] prog_counter;
    logic signed [31:0] stack_pointer;
    logic               trace_valid;
    logic               stopped;
  } out_item_t;

endpackage

// ----- rtl/stack_machine_execute_step.sv -----
// Each item waits in the execute stage register and its result is then registered
// in the output register, held back by an output stall. No new item is taken while
// one is there, since its read-modify-write uses the registered memory read port.
// Reset: registers, halt flag and program line count clear at once; the data
// memory is then cleared one word per cycle, from address 0 up to the last word,
// during which in_stall_o stays high. Configuration writes are taken at any time.
// Top level of the stack machine execute step block; uses smes_pkg.
module stack_machine_execute_step
  import smes_pkg::*;
#(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  in_item_t                in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output out_item_t               out_item_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [PROG_LINES_W-1:0] cfg_data_i
);

  localparam int unsigned MEM_AW = $clog2(MEM_WORDS);
  localparam int unsigned SHW    = $clog2(WORD_BITS);
  localparam logic [WORD_BITS-1:0] SHIFT_LIMIT = WORD_BITS'(WORD_BITS);
  localparam logic [MEM_AW-1:0]    LAST_ADDR   = MEM_AW'(MEM_WORDS - 1);

  // Architectural registers.
  logic [WORD_BITS-1:0] a_q, a_d, b_q, b_d, pc_q, pc_d, sp_q, sp_d;
  logic                 halt_q, halt_d;
  logic [PROG_LINES_W-1:0] prog_lines_q;

  // Memory clearing pass after reset.
  logic              clr_q;
  logic [MEM_AW-1:0] clr_addr_q;

  // Execute stage.
  logic              busy_q;
  in_item_t          item_q;
  logic [MEM_AW-1:0] addr_q;
  logic [WORD_BITS-1:0] rdata_q;

  // Output register.
  logic      out_valid_q;
  out_item_t out_q, out_d;

  logic accept, done;
  logic [WORD_BITS-1:0] in_k, in_base, in_sum;
  logic [MEM_AW-1:0]    in_addr;

  logic [WORD_BITS-1:0] k_w, wdata;
  logic                 run, we, traced;
  logic                 shift_ok;
  logic [SHW-1:0]       shamt;

  logic                 mem_we;
  logic [MEM_AW-1:0]    mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] mem_q [MEM_WORDS];

  assign in_stall_o  = clr_q | busy_q;
  assign accept      = in_valid_i & ~in_stall_o;
  assign done        = busy_q & (~out_valid_q | ~out_stall_i);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Address of the memory access, formed from the registers at accept time, or taken from load_address for a preload.
  always_comb begin
    in_k = WORD_BITS'($signed(in_item_i.operand));
    if (in_item_i.opcode == OP_LDL || in_item_i.opcode == OP_STL) begin
      in_base = sp_q;
    end else begin
      in_base = a_q;
    end
    in_sum = in_base + in_k;
    if (in_item_i.item_kind == KIND_PRELOAD) begin
      in_addr = MEM_AW'(in_item_i.load_address);
    end else begin
      in_addr = in_sum[MEM_AW-1:0];
    end
  end

  // Register updates of the item in the execute stage; registers have not
  // changed since the item was accepted.
  always_comb begin
    k_w      = WORD_BITS'($signed(item_q.operand));
    run      = ~halt_q & ~pc_q[WORD_BITS-1] & (pc_q < WORD_BITS'(prog_lines_q));
    shift_ok = ~a_q[WORD_BITS-1] & (a_q < SHIFT_LIMIT);
    shamt    = a_q[SHW-1:0];
    a_d      = a_q;
    b_d      = b_q;
    pc_d     = pc_q;
    sp_d     = sp_q;
    halt_d   = halt_q;
    traced   = 1'b0;
    we       = 1'b0;
    wdata    = b_q;
    if (item_q.item_kind == KIND_PRELOAD) begin
      we    = 1'b1;
      wdata = WORD_BITS'($signed(item_q.load_value));
    end else if (run) begin
      pc_d = pc_q + 1'b1;
      if (item_q.line_tag != TAG_SKIP) begin
        traced = 1'b1;
      end
      if (item_q.line_tag == TAG_INSTR) begin
        unique case (item_q.opcode)
          OP_LDC: begin
            b_d = a_q;
            a_d = k_w;
          end
          OP_ADC:  a_d = a_q + k_w;
          OP_LDL: begin
            b_d = a_q;
            a_d = rdata_q;
          end
          OP_STL: begin
            we    = 1'b1;
            wdata = a_q;
            a_d   = b_q;
          end
          OP_LDNL: a_d = rdata_q;
          OP_STNL: we = 1'b1;
          OP_ADD:  a_d = a_q + b_q;
          OP_SUB:  a_d = b_q - a_q;
          OP_SHL: begin
            a_d = shift_ok ? (b_q << shamt) : '0;
          end
          OP_SHR: begin
            a_d = shift_ok ? WORD_BITS'($signed(b_q) >>> shamt)
                           : {WORD_BITS{b_q[WORD_BITS-1]}};
          end
          OP_ADJ:  sp_d = sp_q + k_w;
          OP_A2SP: begin
            sp_d = a_q;
            a_d  = b_q;
          end
          OP_SP2A: begin
            b_d = a_q;
            a_d = sp_q;
          end
          OP_CALL: begin
            b_d  = a_q;
            a_d  = pc_q;
            pc_d = pc_q + k_w + 1'b1;
          end
          OP_RET: begin
            pc_d = a_q + 1'b1;
            a_d  = b_q;
          end
          OP_BRZ: begin
            if (a_q == '0) begin
              pc_d = pc_q + k_w + 1'b1;
            end
          end
          OP_BRLZ: begin
            if (a_q[WORD_BITS-1]) begin
              pc_d = pc_q + k_w + 1'b1;
            end
          end
          OP_BR:   pc_d = pc_q + k_w + 1'b1;
          OP_HALT: halt_d = 1'b1;
          default: ;
        endcase
      end
    end

    out_d.reg_a         = a_d[31:0];
    out_d.reg_b         = b_d[31:0];
    out_d.prog_counter  = pc_d[31:0];
    out_d.stack_pointer = sp_d[31:0];
    out_d.trace_valid   = traced;
    out_d.stopped       = halt_d | pc_d[WORD_BITS-1]
                          | (pc_d >= WORD_BITS'(prog_lines_q));
  end

  always_comb begin
    mem_we    = clr_q | (done & we);
    mem_waddr = clr_q ? clr_addr_q : addr_q;
    mem_wdata = clr_q ? '0 : wdata;
  end

  // Data memory: one write port, one read port with registered output.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rdata_q <= mem_q[in_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
      addr_q <= in_addr;
    end
    if (done) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q          <= '0;
      b_q          <= '0;
      pc_q         <= '0;
      sp_q         <= '0;
      halt_q       <= 1'b0;
      prog_lines_q <= '0;
      clr_q        <= 1'b1;
      clr_addr_q   <= '0;
      busy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        prog_lines_q <= cfg_data_i;
      end
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == LAST_ADDR) begin
          clr_q <= 1'b0;
        end
      end
      if (done) begin
        a_q    <= a_d;
        b_q    <= b_d;
        pc_q   <= pc_d;
        sp_q   <= sp_d;
        halt_q <= halt_d;
      end
      if (accept) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
      out_valid_q <= done | (out_valid_q & out_stall_i);
    end
  end

endmodule
